// ===== hdl/stu_pkg.sv =====
// Shared types, token kind codes and the fixed lexical tables of the source tokenizer.
// Used by every module of the block; depends on nothing else.

package stu_pkg;

    // Scanner modes.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_STRING = 2'd3
    } t_mode;

    // Token kind codes.
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_NUMBER  = 5'd1;
    localparam logic [4:0] KIND_STRING  = 5'd2;
    localparam logic [4:0] KIND_KW_BASE = 5'd3;
    localparam logic [4:0] KIND_SYM_BASE = 5'd10;
    localparam logic [4:0] KIND_UNKNOWN = 5'd20;
    localparam logic [4:0] KIND_EOF     = 5'd21;
    localparam logic [4:0] KIND_UNTERM  = 5'd22;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Token queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // Keywords packed first character in the lowest byte, with their lengths.
    localparam logic [39:0] KW_WORD [7] = '{
        40'h00_0072_6176,   // var
        40'h74_6E69_7270,   // print
        40'h00_0072_6F66,   // for
        40'h00_6575_7274,   // true
        40'h65_736C_6166,   // false
        40'h00_0000_6669,   // if
        40'h00_6573_6C65    // else
    };
    localparam logic [2:0] KW_LEN [7] = '{3'd3, 3'd5, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4};

    // Single-character symbols, in kind order.
    localparam logic [7:0] SYM_CHAR [10] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3B, 8'h3D, 8'h28, 8'h29, 8'h7B, 8'h7D
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_byte;
    } t_item;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [15:0] token_length;
        logic [30:0] number_value;
        logic        number_overflow;
        logic [7:0]  unknown_char;
        logic        last_of_run;
    } t_token;

    // Up to two tokens produced by one input transfer, in order.
    typedef struct packed {
        logic   push_a;
        logic   push_b;
        t_token tok_a;
        t_token tok_b;
    } t_scan_push;

    // A length of zero stands for a word too long to be a keyword.
    function automatic logic [4:0] word_kind(input logic [39:0] word, input logic [2:0] len);
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < 7; k++) begin
            if (len == KW_LEN[k] && word == KW_WORD[k]) begin
                kind = 5'(int'(KIND_KW_BASE) + k);
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] kind;
        kind = KIND_UNKNOWN;
        for (int k = 0; k < 10; k++) begin
            if (SYM_CHAR[k] == c) begin
                kind = 5'(int'(KIND_SYM_BASE) + k);
            end
        end
        return kind;
    endfunction

endpackage

// ===== hdl/stu_scanner.sv =====
// Front end of the tokenizer: takes source bytes, keeps the scan state and positions,
// and produces up to two finished tokens per transfer. Depends on stu_pkg.

module stu_scanner #(
    parameter int POS_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  stu_pkg::t_item      i_item,
    output stu_pkg::t_scan_push o_scan
);

    localparam logic [POS_BITS-1:0] POS_ONE   = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] SHORT_LEN = POS_BITS'(5);

    stu_pkg::t_mode r_mode, n_mode;
    logic [POS_BITS-1:0] r_cur_line, n_cur_line;
    logic [POS_BITS-1:0] r_cur_col, n_cur_col;
    logic [POS_BITS-1:0] r_start_line, n_start_line;
    logic [POS_BITS-1:0] r_start_col, n_start_col;
    logic [POS_BITS-1:0] r_run_len, n_run_len;
    logic [30:0] r_accum, n_accum;
    logic        r_sat, n_sat;
    logic [39:0] r_word, n_word;
    logic        r_finished, n_finished;

    logic [7:0]  w_c;
    logic        w_digit, w_alpha, w_space, w_quote;
    logic        w_active, w_byte, w_flush, w_cont_ident, w_cont_num, w_fresh;
    logic [POS_BITS-1:0] w_run_inc;
    logic [34:0] w_prod;
    logic [2:0]  w_kw_len;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] to_pos16(input logic [POS_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[15:0];
    endfunction

    assign w_c     = i_item.char_byte;
    assign w_digit = (w_c >= 8'h30) && (w_c <= 8'h39);
    assign w_alpha = ((w_c >= 8'h61) && (w_c <= 8'h7A)) || ((w_c >= 8'h41) && (w_c <= 8'h5A));
    assign w_space = (w_c == stu_pkg::CHAR_SPACE) || (w_c == stu_pkg::CHAR_CR)
                  || (w_c == stu_pkg::CHAR_TAB) || (w_c == stu_pkg::CHAR_LF);
    assign w_quote = (w_c == stu_pkg::CHAR_QUOTE);

    assign w_active = i_accept && !r_finished;
    assign w_byte   = w_active && (i_item.cmd == stu_pkg::CMD_BYTE);

    // A pending word or number ends on the first byte that cannot extend it.
    assign w_flush      = w_byte && (((r_mode == stu_pkg::MODE_IDENT) && !(w_alpha || w_digit))
                                  || ((r_mode == stu_pkg::MODE_NUMBER) && !w_digit));
    assign w_cont_ident = (r_mode == stu_pkg::MODE_IDENT) && (w_alpha || w_digit);
    assign w_cont_num   = (r_mode == stu_pkg::MODE_NUMBER) && w_digit;
    assign w_fresh      = (r_mode == stu_pkg::MODE_IDLE) || w_flush;

    assign w_run_inc = sat_inc(r_run_len);
    assign w_prod    = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + {31'd0, w_c[3:0]};
    assign w_kw_len  = (r_run_len <= SHORT_LEN) ? r_run_len[2:0] : 3'd0;

    // Next scan mode.
    always_comb begin
        n_mode = r_mode;
        if (w_active) begin
            if (i_item.cmd == stu_pkg::CMD_END) begin
                n_mode = stu_pkg::MODE_IDLE;
            end else begin
                unique case (r_mode)
                    stu_pkg::MODE_STRING: begin
                        if (w_quote) n_mode = stu_pkg::MODE_IDLE;
                    end
                    stu_pkg::MODE_IDENT,
                    stu_pkg::MODE_NUMBER,
                    stu_pkg::MODE_IDLE: begin
                        if (w_cont_ident || w_cont_num) begin
                            n_mode = r_mode;
                        end else if (w_alpha) begin
                            n_mode = stu_pkg::MODE_IDENT;
                        end else if (w_digit) begin
                            n_mode = stu_pkg::MODE_NUMBER;
                        end else if (w_quote) begin
                            n_mode = stu_pkg::MODE_STRING;
                        end else begin
                            n_mode = stu_pkg::MODE_IDLE;
                        end
                    end
                    default: n_mode = stu_pkg::MODE_IDLE;
                endcase
            end
        end
    end

    // Tokens and datapath updates.
    always_comb begin
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_run_len    = r_run_len;
        n_accum      = r_accum;
        n_sat        = r_sat;
        n_word       = r_word;
        n_finished   = r_finished;

        o_scan = '0;

        // The pending token, as it would be closed now.
        o_scan.tok_a.token_line   = to_pos16(r_start_line);
        o_scan.tok_a.token_column = to_pos16(r_start_col);
        o_scan.tok_a.token_length = to_pos16(r_run_len);
        unique case (r_mode)
            stu_pkg::MODE_IDENT:  o_scan.tok_a.token_kind = stu_pkg::word_kind(r_word, w_kw_len);
            stu_pkg::MODE_NUMBER: begin
                o_scan.tok_a.token_kind      = stu_pkg::KIND_NUMBER;
                o_scan.tok_a.number_value    = r_accum;
                o_scan.tok_a.number_overflow = r_sat;
            end
            stu_pkg::MODE_STRING: o_scan.tok_a.token_kind = stu_pkg::KIND_UNTERM;
            default:              o_scan.tok_a.token_kind = stu_pkg::KIND_IDENT;
        endcase

        o_scan.tok_b.last_of_run  = 1'b1;
        o_scan.tok_b.token_line   = to_pos16(r_cur_line);
        o_scan.tok_b.token_column = to_pos16(r_cur_col);

        if (w_active && (i_item.cmd == stu_pkg::CMD_END)) begin
            o_scan.push_a = (r_mode != stu_pkg::MODE_IDLE);
            o_scan.push_b = 1'b1;
            o_scan.tok_b.token_kind = stu_pkg::KIND_EOF;
            n_finished = 1'b1;
        end else if (w_byte) begin
            // Every source byte moves the position on.
            if (w_c == stu_pkg::CHAR_LF) begin
                n_cur_line = sat_inc(r_cur_line);
                n_cur_col  = POS_ONE;
            end else begin
                n_cur_col  = sat_inc(r_cur_col);
            end

            if (r_mode == stu_pkg::MODE_STRING) begin
                n_run_len = w_run_inc;
                if (w_quote) begin
                    o_scan.push_b = 1'b1;
                    o_scan.tok_b.token_kind   = stu_pkg::KIND_STRING;
                    o_scan.tok_b.token_line   = to_pos16(r_start_line);
                    o_scan.tok_b.token_column = to_pos16(r_start_col);
                    o_scan.tok_b.token_length = to_pos16(w_run_inc);
                end
            end else begin
                o_scan.push_a = w_flush;
                if (w_cont_ident) begin
                    if (r_run_len < SHORT_LEN) begin
                        n_word[{r_run_len[2:0], 3'b000} +: 8] = w_c;
                    end
                    n_run_len = w_run_inc;
                end else if (w_cont_num) begin
                    if (w_prod[34:31] != 4'd0) begin
                        n_accum = stu_pkg::NUM_MAX;
                        n_sat   = 1'b1;
                    end else begin
                        n_accum = w_prod[30:0];
                    end
                    n_run_len = w_run_inc;
                end else if (w_fresh && !w_space) begin
                    if (w_alpha || w_digit || w_quote) begin
                        n_start_line = r_cur_line;
                        n_start_col  = r_cur_col;
                        n_run_len    = POS_ONE;
                        n_accum      = w_digit ? {27'd0, w_c[3:0]} : 31'd0;
                        n_sat        = 1'b0;
                        n_word       = w_alpha ? {32'd0, w_c} : 40'd0;
                    end else begin
                        o_scan.push_b = 1'b1;
                        o_scan.tok_b.token_kind   = stu_pkg::symbol_kind(w_c);
                        o_scan.tok_b.token_length = 16'd1;
                        if (stu_pkg::symbol_kind(w_c) == stu_pkg::KIND_UNKNOWN) begin
                            o_scan.tok_b.unknown_char = w_c;
                        end
                    end
                end
            end
        end

        o_scan.tok_a.last_of_run = !o_scan.push_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= stu_pkg::MODE_IDLE;
            r_cur_line   <= POS_ONE;
            r_cur_col    <= POS_ONE;
            r_start_line <= POS_ONE;
            r_start_col  <= POS_ONE;
            r_run_len    <= '0;
            r_accum      <= '0;
            r_sat        <= 1'b0;
            r_word       <= '0;
            r_finished   <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_run_len    <= n_run_len;
            r_accum      <= n_accum;
            r_sat        <= n_sat;
            r_word       <= n_word;
            r_finished   <= n_finished;
        end
    end

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("end of source state was lost");

    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !(o_scan.push_a || o_scan.push_b))
        else $error("token produced after end of source");

    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_scan.push_a && !o_scan.push_b) |-> o_scan.tok_a.last_of_run)
        else $error("lone token not marked as last of its run");

endmodule

// ===== hdl/stu_token_queue.sv =====
// Small token queue between scanner and output stage: two writes and one read per cycle.
// Depends on stu_pkg for the token type and queue size.

module stu_token_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stu_pkg::t_scan_push i_scan,
    input  logic                i_pop,
    output logic                o_nonempty,
    output logic                o_nearly_full,
    output stu_pkg::t_token     o_head
);

    stu_pkg::t_token r_mem [stu_pkg::QUEUE_DEPTH];
    logic [stu_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [stu_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [stu_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic [stu_pkg::QUEUE_AW-1:0] w_wr_next;
    logic [stu_pkg::QUEUE_CW-1:0] w_pushes;

    assign w_wr_next = r_wr_ptr + stu_pkg::QUEUE_AW'(1);
    assign w_pushes  = stu_pkg::QUEUE_CW'(i_scan.push_a) + stu_pkg::QUEUE_CW'(i_scan.push_b);

    assign n_wr_ptr = r_wr_ptr + w_pushes[stu_pkg::QUEUE_AW-1:0];
    assign n_rd_ptr = r_rd_ptr + stu_pkg::QUEUE_AW'(i_pop);
    assign n_count  = r_count + w_pushes - stu_pkg::QUEUE_CW'(i_pop);

    assign o_nonempty    = (r_count != '0);
    // Room for two tokens is kept for every transfer that the scanner takes.
    assign o_nearly_full = (r_count > stu_pkg::QUEUE_CW'(stu_pkg::QUEUE_DEPTH - 2));
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_scan.push_a) begin
            r_mem[r_wr_ptr] <= i_scan.tok_a;
            if (i_scan.push_b) r_mem[w_wr_next] <= i_scan.tok_b;
        end else if (i_scan.push_b) begin
            r_mem[r_wr_ptr] <= i_scan.tok_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stu_pkg::QUEUE_CW'(stu_pkg::QUEUE_DEPTH))
        else $error("token queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("token queue read while empty");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pushes != '0) |-> (r_count <= stu_pkg::QUEUE_CW'(stu_pkg::QUEUE_DEPTH - 2)))
        else $error("token queue written without room for two tokens");

endmodule

// ===== hdl/stu_emitter.sv =====
// Back end of the tokenizer: output register that presents one token per transfer.
// Depends on stu_pkg for the token type.

module stu_emitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  stu_pkg::t_token i_head,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output stu_pkg::t_token o_out_token
);

    logic            r_valid;
    stu_pkg::t_token r_token;

    // Load a new token whenever the register is empty or its token leaves this cycle.
    assign o_pop       = i_nonempty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_token = r_token;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_token <= i_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== hdl/source_tokenizer_unit.sv =====
// Top level of the source tokenizer: scanner, token queue and output register.
// Depends on stu_pkg, stu_scanner, stu_token_queue and stu_emitter.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) carries one source byte per
//   transfer, or an end-of-source command. Output channel (o_out_valid, i_out_stall,
//   o_out_token) carries tokens, one per transfer, in source order.
//   One input byte is taken every cycle while o_in_stall is low. A byte gives zero,
//   one or two tokens; the last token caused by a transfer has last_of_run set. End
//   of source gives any pending token, then an end-of-file token, and every later
//   input is taken and dropped. Tokens pass through the queue to the output register.
//   Unless i_out_stall is high, the output side delivers one token per cycle, so a
//   long run of bytes that each give two tokens is paced by the output register and
//   the four-entry queue: o_in_stall rises while fewer than two queue entries are free.
//   When the receiver stalls, the output token holds, the queue fills and the input
//   channel is stalled in turn; nothing is lost.
//   Reset (synchronous, active low) empties the queue and output register and returns
//   the scanner to line 1, column 1, with no pending token.
//   POS_BITS sets the width of the line, column and length counters, which saturate.

module source_tokenizer_unit #(
    parameter int POS_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  stu_pkg::t_item  i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output stu_pkg::t_token o_out_token
);

    stu_pkg::t_scan_push w_scan;
    stu_pkg::t_token     w_head;
    logic                w_nonempty;
    logic                w_nearly_full;
    logic                w_pop;
    logic                w_accept;

    assign o_in_stall = w_nearly_full;
    assign w_accept   = i_in_valid && !w_nearly_full;

    stu_scanner #(
        .POS_BITS (POS_BITS)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_scan   (w_scan)
    );

    stu_token_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan        (w_scan),
        .i_pop         (w_pop),
        .o_nonempty    (w_nonempty),
        .o_nearly_full (w_nearly_full),
        .o_head        (w_head)
    );

    stu_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (w_nonempty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_token (o_out_token)
    );

endmodule
